[rtl/core/wzpm_pkg.sv]
// package for the window zoom pixel mapper
// image geometry, register indexes, item modes and address helper; no dependencies
package wzpm_pkg;

    localparam int unsigned IMAGE_WIDTH  = 320;
    localparam int unsigned IMAGE_HEIGHT = 240;
    localparam int unsigned STORE_DEPTH  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int unsigned STORE_ADDR_W = $clog2(STORE_DEPTH);

    localparam int unsigned PIX_W  = 8;
    localparam int unsigned COL_W  = 9;
    localparam int unsigned ROW_W  = 8;
    localparam int unsigned ZOOM_W = 2;
    localparam int unsigned CFG_W  = 9;
    localparam int unsigned ADDR_W = 17;

    localparam logic [PIX_W-1:0] WHITE_LEVEL = 8'd255;

    typedef enum logic [2:0] {
        REG_CORNER_A_X = 3'd0,
        REG_CORNER_A_Y = 3'd1,
        REG_CORNER_B_X = 3'd2,
        REG_CORNER_B_Y = 3'd3,
        REG_ZOOM_SHIFT = 3'd4
    } cfg_reg_t;

    typedef enum logic {
        MODE_LOAD  = 1'b0,
        MODE_QUERY = 1'b1
    } mode_t;

    // row-major linear address of a pixel
    function automatic logic [31:0] lin_addr(input logic [31:0] x, input logic [31:0] y);
        return y * IMAGE_WIDTH + x;
    endfunction

endpackage

[rtl/core/wzpm_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module wzpm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/window_zoom_pixel_mapper_unit.sv]
// window zoom pixel mapper top level
// depends on wzpm_pkg and wzpm_ram
//
// Holds one grayscale frame in an image store and answers display queries
// against a zoom window set by five configuration registers. A load item
// writes one pixel and gives no result; a query item gives one result item
// with the covered flag, the linear display address and the pixel value.
// The block takes one item per clock while no untaken result holds a query
// in the input register. A query sits in the input register, where the window
// test and the source address are worked out; when the output stage frees,
// the registered read port of the image store and the output register load
// together, and the result item is presented from the output register.
// A result that is not taken holds the query behind it in the input
// register. Loads are written from the input register and leave it at once,
// whatever the output side is doing. The store has no reset; pixels that
// were never loaded read as whatever the memory holds.
module window_zoom_pixel_mapper_unit (
    input  logic                         aclk,
    input  logic                         aresetn,

    input  logic                         cfg_wr_en,
    input  logic [2:0]                   cfg_index,
    input  logic [wzpm_pkg::CFG_W-1:0]   cfg_wr_data,

    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_mode,
    input  logic [wzpm_pkg::COL_W-1:0]   s_pos_x,
    input  logic [wzpm_pkg::ROW_W-1:0]   s_pos_y,
    input  logic [wzpm_pkg::PIX_W-1:0]   s_load_value,

    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_covered,
    output logic [wzpm_pkg::ADDR_W-1:0]  m_pixel_address,
    output logic [wzpm_pkg::PIX_W-1:0]   m_pixel_value
);

    import wzpm_pkg::*;

    // configuration registers
    logic [COL_W-1:0]  corner_a_x_reg, corner_b_x_reg;
    logic [ROW_W-1:0]  corner_a_y_reg, corner_b_y_reg;
    logic [ZOOM_W-1:0] zoom_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_a_x_reg <= '0;
            corner_a_y_reg <= '0;
            corner_b_x_reg <= '0;
            corner_b_y_reg <= '0;
            zoom_shift_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_index))
                REG_CORNER_A_X: corner_a_x_reg <= cfg_wr_data;
                REG_CORNER_A_Y: corner_a_y_reg <= cfg_wr_data[ROW_W-1:0];
                REG_CORNER_B_X: corner_b_x_reg <= cfg_wr_data;
                REG_CORNER_B_Y: corner_b_y_reg <= cfg_wr_data[ROW_W-1:0];
                REG_ZOOM_SHIFT: zoom_shift_reg <= cfg_wr_data[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    // input register stage
    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic [COL_W-1:0]  s1_x_reg;
    logic [ROW_W-1:0]  s1_y_reg;
    logic [PIX_W-1:0]  s1_val_reg;

    // output stage
    logic              s2_valid_reg;
    logic              s2_covered_reg;
    logic              s2_use_ram_reg;
    logic [ADDR_W-1:0] s2_addr_reg;
    logic [PIX_W-1:0]  s2_const_reg;

    logic s1_is_query;
    logic advance;
    logic s1_leave;
    logic s_accept;

    assign s1_is_query = (s1_mode_reg == MODE_QUERY);
    // output stage frees when empty or being taken
    assign advance     = !s2_valid_reg || m_ready;
    // loads leave the input register without waiting for the output side
    assign s1_leave    = s1_valid_reg && (!s1_is_query || advance);
    assign s_ready     = !s1_valid_reg || s1_leave;
    assign s_accept    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_leave) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_mode_reg <= s_mode;
            s1_x_reg    <= s_pos_x;
            s1_y_reg    <= s_pos_y;
            s1_val_reg  <= s_load_value;
        end
    end

    // sorted window
    logic [COL_W-1:0]  xs, xe, win_w;
    logic [ROW_W-1:0]  ys, ye, win_h;

    assign xs    = (corner_a_x_reg < corner_b_x_reg) ? corner_a_x_reg : corner_b_x_reg;
    assign xe    = (corner_a_x_reg < corner_b_x_reg) ? corner_b_x_reg : corner_a_x_reg;
    assign ys    = (corner_a_y_reg < corner_b_y_reg) ? corner_a_y_reg : corner_b_y_reg;
    assign ye    = (corner_a_y_reg < corner_b_y_reg) ? corner_b_y_reg : corner_a_y_reg;
    assign win_w = xe - xs;
    assign win_h = ye - ys;

    // window test and source coordinate
    logic              wide_ok, pos_inside, in_full, in_zoom, border, src_inside;
    logic [COL_W-1:0]  dx, off_x;
    logic [ROW_W-1:0]  dy, off_y;
    logic [COL_W:0]    src_x;
    logic [ROW_W:0]    src_y;
    logic [31:0]       pos_lin, src_lin;

    assign wide_ok    = (win_w > COL_W'(1)) && (win_h > ROW_W'(1));
    assign pos_inside = (32'(s1_x_reg) < 32'(IMAGE_WIDTH)) && (32'(s1_y_reg) < 32'(IMAGE_HEIGHT));
    // zoom 1x takes the window inclusive of its end corner
    assign in_full    = (s1_x_reg >= xs) && (s1_x_reg <= xe) &&
                        (s1_y_reg >= ys) && (s1_y_reg <= ye);
    // higher zoom drops the last row and column
    assign in_zoom    = (s1_x_reg >= xs) && (s1_x_reg < xe) &&
                        (s1_y_reg >= ys) && (s1_y_reg < ye);
    assign dx         = s1_x_reg - xs;
    assign dy         = s1_y_reg - ys;
    assign border     = (dx == '0) || (dx == win_w - COL_W'(1)) ||
                        (dy == '0) || (dy == win_h - ROW_W'(1));

    // centre the replicated part inside the window
    assign off_x      = (win_w - (win_w >> zoom_shift_reg)) >> 1;
    assign off_y      = (win_h - (win_h >> zoom_shift_reg)) >> 1;
    assign src_x      = (COL_W+1)'(xs) + (COL_W+1)'(off_x) + (COL_W+1)'(dx >> zoom_shift_reg);
    assign src_y      = (ROW_W+1)'(ys) + (ROW_W+1)'(off_y) + (ROW_W+1)'(dy >> zoom_shift_reg);
    assign src_inside = (32'(src_x) < 32'(IMAGE_WIDTH)) && (32'(src_y) < 32'(IMAGE_HEIGHT));

    assign pos_lin    = lin_addr(32'(s1_x_reg), 32'(s1_y_reg));
    assign src_lin    = lin_addr(32'(src_x), 32'(src_y));

    logic                    q_covered, q_use_ram;
    logic [PIX_W-1:0]        q_const;
    logic [STORE_ADDR_W-1:0] q_rd_addr;

    always_comb begin
        q_covered = 1'b0;
        q_use_ram = 1'b0;
        q_const   = '0;
        q_rd_addr = pos_lin[STORE_ADDR_W-1:0];
        if (wide_ok && pos_inside) begin
            if (zoom_shift_reg == '0) begin
                if (in_full) begin
                    q_covered = 1'b1;
                    q_use_ram = 1'b1;
                end
            end else if (in_zoom) begin
                q_covered = 1'b1;
                if (border) begin
                    q_const = WHITE_LEVEL;
                end else if (src_inside) begin
                    q_use_ram = 1'b1;
                    q_rd_addr = src_lin[STORE_ADDR_W-1:0];
                end
            end
        end
    end

    // image store
    logic             ram_wr_en, ram_rd_en;
    logic [PIX_W-1:0] ram_rd_data;

    // a load leaves the input register in the cycle it is written
    assign ram_wr_en = s1_valid_reg && !s1_is_query && pos_inside;
    assign ram_rd_en = s1_valid_reg && s1_is_query && advance && q_use_ram;

    wzpm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_lin[STORE_ADDR_W-1:0]),
        .wr_data (s1_val_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output stage, moves in step with the store read port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (advance) begin
            s2_valid_reg <= s1_valid_reg && s1_is_query;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid_reg && s1_is_query) begin
            s2_covered_reg <= q_covered;
            s2_use_ram_reg <= q_use_ram;
            s2_addr_reg    <= pos_lin[ADDR_W-1:0];
            s2_const_reg   <= q_const;
        end
    end

    assign m_valid         = s2_valid_reg;
    assign m_covered       = s2_covered_reg;
    assign m_pixel_address = s2_addr_reg;
    assign m_pixel_value   = s2_use_ram_reg ? ram_rd_data : s2_const_reg;

    // a store read always lands in a valid result item
    a_read_gives_item: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_rd_en |=> (m_valid && s2_use_ram_reg))
        else $error("store read without a following result item");

    // one item in the input register cannot both write and read the store
    a_no_write_with_read: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_wr_en && ram_rd_en))
        else $error("store written and read by the same item");

    // an uncovered result shows black
    a_uncovered_black: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_covered) |-> (m_pixel_value == '0))
        else $error("uncovered pixel with non-zero value");

    // a load never produces a result item
    a_load_no_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !s1_is_query && !s2_valid_reg) |=> !s2_valid_reg)
        else $error("load item produced a result");

endmodule
